>>> design/pixel_scattering_angle_map_defines.svh
// Assertion macros for the pixel scattering angle map.
// Included by the top-level module, which carries the concurrent checks; no other dependencies.
`ifndef PIXEL_SCATTERING_ANGLE_MAP_DEFINES_SVH
`define PIXEL_SCATTERING_ANGLE_MAP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PSAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psam check failed");
// Next-cycle implication, disabled during reset.
`define PSAM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psam check failed");
`else
`define PSAM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSAM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/psam_pkg.sv
// Shared types, widths and constants of the pixel scattering angle map.
// No dependencies.
`default_nettype none
package psam_pkg;
    localparam int MAX_SIDE_DEF = 4096;
    localparam int CORDIC_STEPS = 23;
    localparam int CW           = 52;   // CORDIC datapath width
    localparam int AW           = 26;   // angle accumulator width
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(5898240);
    localparam logic signed [AW-1:0] HALF_TURN    = AW'(11796480);
    localparam logic [23:0]          INV_GAIN_Q24 = 24'd10188014;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CCOL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd5;

    typedef struct packed {
        logic        [23:0] distance;
        logic        [20:0] pitch;
        logic signed [13:0] centre_column;
        logic signed [13:0] centre_row;
        logic signed [17:0] cos_angle;
        logic signed [17:0] sin_angle;
    } t_cfg;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

>>> design/psam_front.sv
// Geometry front end: pixel offset, pitch scaling and rotation into beam axes.
// Four register stages; uses psam_pkg.
`default_nettype none
module psam_front #(
    parameter int MAX_SIDE = psam_pkg::MAX_SIDE_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  wire  [11:0]                       i_col,
    input  wire  [11:0]                       i_row,
    input  psam_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    output logic signed [psam_pkg::CW-1:0]    o_bx,
    output logic signed [psam_pkg::CW-1:0]    o_by,
    output logic signed [psam_pkg::CW-1:0]    o_bz
);
    localparam logic [16:0] SIDE     = 17'(MAX_SIDE);
    localparam logic [11:0] SIDE_TOP = 12'(MAX_SIDE - 1);

    logic [11:0]        w_col, w_row;
    logic [3:0]         r_valid;
    logic signed [14:0] r_dcol, r_drow;
    logic signed [36:0] r_dx, r_by2, r_by3;
    logic signed [42:0] r_ds2, r_dc2, r_ds3, r_dc3;
    logic signed [54:0] r_dxc, r_dxs;
    logic signed [psam_pkg::CW-1:0] r_bx, r_by, r_bz;

    // clamp indexes beyond the detector side
    assign w_col = ({5'b0, i_col} >= SIDE) ? SIDE_TOP : i_col;
    assign w_row = ({5'b0, i_row} >= SIDE) ? SIDE_TOP : i_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dcol <= $signed({3'b0, w_col})
                      - $signed({i_cfg.centre_column[13], i_cfg.centre_column});
            r_drow <= $signed({i_cfg.centre_row[13], i_cfg.centre_row})
                      - $signed({3'b0, w_row});
            r_dx   <= r_dcol * $signed({1'b0, i_cfg.pitch});
            r_by2  <= r_drow * $signed({1'b0, i_cfg.pitch});
            r_ds2  <= $signed({1'b0, i_cfg.distance}) * i_cfg.sin_angle;
            r_dc2  <= $signed({1'b0, i_cfg.distance}) * i_cfg.cos_angle;
            r_dxc  <= r_dx * i_cfg.cos_angle;
            r_dxs  <= r_dx * i_cfg.sin_angle;
            r_by3  <= r_by2;
            r_ds3  <= r_ds2;
            r_dc3  <= r_dc2;
            r_bx   <= psam_pkg::CW'(r_ds3) + psam_pkg::CW'((r_dxc + 55'sd128) >>> 8);
            r_bz   <= psam_pkg::CW'(r_dc3) - psam_pkg::CW'((r_dxs + 55'sd128) >>> 8);
            r_by   <= psam_pkg::CW'(r_by3) <<< 8;
        end
    end

    assign o_valid = r_valid[3];
    assign o_bx    = r_bx;
    assign o_by    = r_by;
    assign o_bz    = r_bz;
endmodule
`default_nettype wire

>>> design/psam_cordic.sv
// Pipelined CORDIC in vectoring mode: one quadrant stage, then one stage per step.
// Carries a sideband word alongside; uses psam_pkg.
`default_nettype none
module psam_cordic #(
    parameter int SW = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  wire  signed [psam_pkg::CW-1:0]    i_x,
    input  wire  signed [psam_pkg::CW-1:0]    i_y,
    input  wire  [SW-1:0]                     i_side,
    output logic                              o_valid,
    output logic signed [psam_pkg::CW-1:0]    o_mag,
    output logic signed [psam_pkg::AW-1:0]    o_angle,
    output logic [SW-1:0]                     o_side
);
    localparam int N  = psam_pkg::CORDIC_STEPS;
    localparam int CW = psam_pkg::CW;
    localparam int AW = psam_pkg::AW;

    logic                 r_valid [0:N];
    logic                 r_zero  [0:N];
    logic signed [CW-1:0] r_x     [0:N];
    logic signed [CW-1:0] r_y     [0:N];
    logic signed [AW-1:0] r_z     [0:N];
    logic [SW-1:0]        r_side  [0:N];

    // quadrant stage: fold the left half plane onto the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_side[0] <= i_side;
            if (i_x[CW-1] && !i_y[CW-1]) begin
                r_x[0] <= i_y;
                r_y[0] <= -i_x;
                r_z[0] <= psam_pkg::QUARTER_TURN;
            end else if (i_x[CW-1]) begin
                r_x[0] <= -i_y;
                r_y[0] <= i_x;
                r_z[0] <= -psam_pkg::QUARTER_TURN;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam logic signed [AW-1:0] ATAN = AW'(psam_pkg::atan_entry(5'(g)));
        logic signed [CW-1:0] w_xs, w_ys;
        assign w_xs = r_x[g] >>> g;
        assign w_ys = r_y[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                r_side[g+1] <= r_side[g];
                if (!r_y[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] + w_ys;
                    r_y[g+1] <= r_y[g] - w_xs;
                    r_z[g+1] <= r_z[g] + ATAN;
                end else begin
                    r_x[g+1] <= r_x[g] - w_ys;
                    r_y[g+1] <= r_y[g] + w_xs;
                    r_z[g+1] <= r_z[g] - ATAN;
                end
            end
        end
    end

    // a zero vector gives angle and magnitude zero
    assign o_valid = r_valid[N];
    assign o_mag   = r_zero[N] ? '0 : r_x[N];
    assign o_angle = r_zero[N] ? '0 : r_z[N];
    assign o_side  = r_side[N];
endmodule
`default_nettype wire

>>> design/psam_scale.sv
// Gain correction of the first CORDIC magnitude: multiply by 1/K in Q24, round.
// Two register stages; uses psam_pkg.
`default_nettype none
module psam_scale (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  wire  signed [psam_pkg::CW-1:0]    i_mag,
    input  wire  signed [psam_pkg::AW-1:0]    i_gam,
    input  wire  signed [psam_pkg::CW-1:0]    i_bz,
    output logic                              o_valid,
    output logic signed [psam_pkg::CW-1:0]    o_r,
    output logic signed [psam_pkg::AW-1:0]    o_gam,
    output logic signed [psam_pkg::CW-1:0]    o_bz
);
    localparam int CW = psam_pkg::CW;

    logic [1:0]           r_valid;
    logic [55:0]          r_ph;
    logic [39:0]          r_pl;
    logic [56:0]          w_t;
    logic signed [psam_pkg::AW-1:0] r_gam1, r_gam2;
    logic signed [CW-1:0] r_bz1, r_bz2, r_r;

    // magnitude is nonnegative and below 2^48
    assign w_t = {1'b0, r_ph} + {17'b0, r_pl[39:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph   <= i_mag[47:16] * psam_pkg::INV_GAIN_Q24;
            r_pl   <= i_mag[15:0] * psam_pkg::INV_GAIN_Q24;
            r_gam1 <= i_gam;
            r_bz1  <= i_bz;
            r_r    <= $signed(CW'((w_t + 57'd128) >> 8));
            r_gam2 <= r_gam1;
            r_bz2  <= r_bz1;
        end
    end

    assign o_valid = r_valid[1];
    assign o_r     = r_r;
    assign o_gam   = r_gam2;
    assign o_bz    = r_bz2;
endmodule
`default_nettype wire

>>> design/pixel_scattering_angle_map.sv
// Top level: configuration registers, geometry front end, two CORDIC pipelines,
// gain scaling and the output register. Uses psam_pkg and the psam_* modules.
//
//   channel  dir  tdata bits (low first)                 handshake
//   s        in   pixel_column[11:0], pixel_row[23:12]   i_s_tvalid/o_s_tready
//   m        out  two_theta[23:0], gamma_angle[48:24]    o_m_tvalid/i_m_tready
//   cfg      in   i_cfg_idx selects, i_cfg_data value    i_cfg_wr_en
//
// One pixel per cycle while not stalled; stages in order: front end, gamma CORDIC, scaling,
// two-theta CORDIC, output register.
// The whole pipeline advances whenever the output register is empty or being taken;
// a stall freezes every stage with its valid bit.
// Synchronous active-low reset clears valid bits and loads the default geometry.
`default_nettype none
`include "pixel_scattering_angle_map_defines.svh"
module pixel_scattering_angle_map #(
    parameter int MAX_SIDE = psam_pkg::MAX_SIDE_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [23:0]                        i_s_tdata,  // pixel_column, pixel_row
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [55:0]                        o_m_tdata,  // two_theta, gamma_angle, pad
    input  wire                                i_cfg_wr_en,
    input  wire  [psam_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [psam_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int CW = psam_pkg::CW;
    localparam int AW = psam_pkg::AW;

    psam_pkg::t_cfg r_cfg;
    logic w_en;
    logic w_f_valid, w_c1_valid, w_s_valid, w_c2_valid;
    logic signed [CW-1:0] w_bx, w_by, w_bz, w_mag1, w_bz1, w_r, w_bz2, w_mag2;
    logic signed [AW-1:0] w_gam1, w_gam2, w_tth;
    logic [CW-1:0] w_side1;
    logic [AW-1:0] w_side2;
    logic        r_out_valid;
    logic [23:0] r_tth;
    logic [24:0] r_gam;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance      <= 24'd264960;
            r_cfg.pitch         <= 21'd65536;
            r_cfg.centre_column <= '0;
            r_cfg.centre_row    <= '0;
            r_cfg.cos_angle     <= 18'sd65536;
            r_cfg.sin_angle     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                psam_pkg::REG_DISTANCE: r_cfg.distance      <= i_cfg_data;
                psam_pkg::REG_PITCH:    r_cfg.pitch         <= i_cfg_data[20:0];
                psam_pkg::REG_CCOL:     r_cfg.centre_column <= $signed(i_cfg_data[13:0]);
                psam_pkg::REG_CROW:     r_cfg.centre_row    <= $signed(i_cfg_data[13:0]);
                psam_pkg::REG_COS:      r_cfg.cos_angle     <= $signed(i_cfg_data[17:0]);
                psam_pkg::REG_SIN:      r_cfg.sin_angle     <= $signed(i_cfg_data[17:0]);
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    psam_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_s_tvalid && w_en),
        .i_col(i_s_tdata[11:0]), .i_row(i_s_tdata[23:12]), .i_cfg(r_cfg),
        .o_valid(w_f_valid), .o_bx(w_bx), .o_by(w_by), .o_bz(w_bz)
    );

    // gamma = atan2(by, bx); bz rides along
    psam_cordic #(.SW(CW)) u_cordic_gam (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_f_valid),
        .i_x(w_bx), .i_y(w_by), .i_side(w_bz),
        .o_valid(w_c1_valid), .o_mag(w_mag1), .o_angle(w_gam1), .o_side(w_side1)
    );
    assign w_bz1 = $signed(w_side1);

    psam_scale u_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_c1_valid),
        .i_mag(w_mag1), .i_gam(w_gam1), .i_bz(w_bz1),
        .o_valid(w_s_valid), .o_r(w_r), .o_gam(w_gam2), .o_bz(w_bz2)
    );

    // two-theta = atan2(radius, bz); gamma rides along
    psam_cordic #(.SW(AW)) u_cordic_tth (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_s_valid),
        .i_x(w_bz2), .i_y(w_r), .i_side(w_gam2),
        .o_valid(w_c2_valid), .o_mag(w_mag2), .o_angle(w_tth), .o_side(w_side2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_c2_valid;
        end
    end

    // clamp CORDIC overshoot into the legal angle ranges
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_tth[AW-1]) begin
                r_tth <= '0;
            end else if (w_tth > psam_pkg::HALF_TURN) begin
                r_tth <= psam_pkg::HALF_TURN[23:0];
            end else begin
                r_tth <= w_tth[23:0];
            end
            if ($signed(w_side2) > psam_pkg::HALF_TURN) begin
                r_gam <= psam_pkg::HALF_TURN[24:0];
            end else if ($signed(w_side2) < -psam_pkg::HALF_TURN) begin
                r_gam <= 25'((-psam_pkg::HALF_TURN));
            end else begin
                r_gam <= w_side2[24:0];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_gam, r_tth};

    `PSAM_ASSERT_IMP(a_tth_range, i_clk, i_rst_n, r_out_valid, r_tth <= 24'd11796480)
    `PSAM_ASSERT_IMP(a_gam_range, i_clk, i_rst_n, r_out_valid,
        ($signed(r_gam) <= 25'sd11796480) && ($signed(r_gam) >= -25'sd11796480))
    `PSAM_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, !o_s_tready, r_out_valid)
    `PSAM_ASSERT_NXT(a_mag_pos, i_clk, i_rst_n, w_c2_valid && w_en, !$past(w_mag2[CW-1]))
endmodule
`default_nettype wire
